[design/nor_flash_array_model_unit_assert.svh]
// Assertion macros shared by the checker of the flash array model block.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef NOR_FLASH_ARRAY_MODEL_UNIT_ASSERT_SVH
`define NOR_FLASH_ARRAY_MODEL_UNIT_ASSERT_SVH

// Checked only while the block is out of reset.
`define NFAM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define NFAM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/nfam_pkg.sv]
// Shared types and constants of the flash array model block.
// No dependencies; used by the top level and its checker.
package nfam_pkg;

    localparam int OP_W     = 3;
    localparam int START_W  = 24;
    localparam int RUN_W    = 17;
    localparam int OFFSET_W = 16;
    localparam int DATA_W   = 8;
    // One bit more than a start address, so that start plus length never wraps.
    localparam int SUM_W    = START_W + 1;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [START_W-1:0]  start_t;
    typedef logic [RUN_W-1:0]    run_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [DATA_W-1:0]   data_t;
    typedef logic [SUM_W-1:0]    sum_t;

    localparam op_t OP_READ    = 3'd0;
    localparam op_t OP_PROGRAM = 3'd1;
    localparam op_t OP_SECTOR  = 3'd2;
    localparam op_t OP_CHIP    = 3'd3;
    localparam op_t OP_FAULT   = 3'd4;

    localparam data_t ERASED_BYTE = 8'hFF;
    localparam data_t FAULT_BIT   = 8'h01;

endpackage

[design/nfam_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module nfam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[design/nor_flash_array_model_unit.sv]
// Top level of the NOR flash array model: a byte array in one RAM with a small sequencer.
// Depends on nfam_pkg and nfam_ram.
//
//   channel | direction | handshake           | beat payload
//   --------+-----------+---------------------+-----------------------------------------------
//   in      | into      | in_valid / in_stall | operation, start_address, run_bytes,
//           |           |                     | byte_offset, write_data
//   out     | out of    | out_valid/out_stall | read_data, status
//
// Read, program and fault beats read the RAM when accepted and finish in ST_MODIFY, where
// program and fault write the changed byte back. Rejected beats and unused operation codes
// are answered from ST_IDLE. A sector erase finds the sector base in the accepting cycle
// by clearing the low address bits, then makes one RAM write per byte of the sector (fewer
// for a clipped last sector). A chip erase makes one RAM write per byte of the array.
// After reset a clearing pass writes 0xFF to every byte; in_stall stays high until it is
// over. A stalled result sits in the output register while one more beat may be taken and
// worked on; that beat's result then waits until the register frees.
module nor_flash_array_model_unit #(
    parameter int MEMORY_BYTES = 65536,
    parameter int SECTOR_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  nfam_pkg::op_t      operation,
    input  nfam_pkg::start_t   start_address,
    input  nfam_pkg::run_t     run_bytes,
    input  nfam_pkg::offset_t  byte_offset,
    input  nfam_pkg::data_t    write_data,
    output logic               out_valid,
    input  logic               out_stall,
    output nfam_pkg::data_t    read_data,
    output logic               status
);

    // Byte address width of the array.
    localparam int ADDR_W = $clog2(MEMORY_BYTES);

    localparam nfam_pkg::sum_t MEM_LIM   = nfam_pkg::sum_t'(MEMORY_BYTES);
    localparam nfam_pkg::sum_t SEC_SIZE  = nfam_pkg::sum_t'(SECTOR_BYTES);
    // SECTOR_BYTES must be a power of two, which the block does not check, so that a sector
    // base is an address with its low bits cleared.
    localparam nfam_pkg::sum_t SEC_MASK  = ~(SEC_SIZE - nfam_pkg::sum_t'(1));
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEMORY_BYTES - 1);

    // Sequencer states.
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [ST_W-1:0] ST_MODIFY = 3'd1;
    localparam logic [ST_W-1:0] ST_SWEEP  = 3'd3;
    localparam logic [ST_W-1:0] ST_DONE   = 3'd4;

    logic [ST_W-1:0]   state_reg, state_next;
    nfam_pkg::op_t     op_reg, op_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    nfam_pkg::data_t   wdata_reg, wdata_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0] sweep_last_reg, sweep_last_next;
    logic              report_reg, report_next;
    nfam_pkg::data_t   pend_rdata_reg, pend_rdata_next;
    logic              pend_status_reg, pend_status_next;
    logic              out_valid_reg, out_valid_next;
    nfam_pkg::data_t   out_rdata_reg, out_rdata_next;
    logic              out_status_reg, out_status_next;

    // RAM ports.
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    nfam_pkg::data_t   ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    nfam_pkg::data_t   ram_rd_data;

    // Range checks on the incoming beat. The run check covers the whole run of a read or program.
    logic run_ok;
    logic addr_ok;
    assign run_ok  = ((nfam_pkg::sum_t'(start_address) + nfam_pkg::sum_t'(run_bytes)) <= MEM_LIM)
                     && (nfam_pkg::run_t'(byte_offset) < run_bytes);
    assign addr_ok = nfam_pkg::sum_t'(start_address) < MEM_LIM;

    // Byte touched by the beat. A fault hits the start address itself; reads and programs
    // add the offset. Out-of-range beats never use this address.
    nfam_pkg::sum_t item_sum;
    assign item_sum    = (operation == nfam_pkg::OP_FAULT)
                         ? nfam_pkg::sum_t'(start_address)
                         : nfam_pkg::sum_t'(start_address) + nfam_pkg::sum_t'(byte_offset);
    assign ram_rd_addr = item_sum[ADDR_W-1:0];

    // Sector bounds of the incoming beat. The end is clipped at the array end, so a partial
    // last sector never writes beyond it.
    nfam_pkg::sum_t sec_base;
    nfam_pkg::sum_t sec_end_raw;
    nfam_pkg::sum_t sec_end;
    nfam_pkg::sum_t sec_last;
    assign sec_base    = nfam_pkg::sum_t'(start_address) & SEC_MASK;
    assign sec_end_raw = sec_base + SEC_SIZE;
    assign sec_end     = (sec_end_raw > MEM_LIM) ? MEM_LIM : sec_end_raw;
    assign sec_last    = sec_end - nfam_pkg::sum_t'(1);

    // The output register can take a result when it is empty or is being emptied now.
    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;

    logic            fin_valid;
    nfam_pkg::data_t fin_rdata;
    logic            fin_status;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        addr_next        = addr_reg;
        wdata_next       = wdata_reg;
        sweep_addr_next  = sweep_addr_reg;
        sweep_last_next  = sweep_last_reg;
        report_next      = report_reg;
        pend_rdata_next  = pend_rdata_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_rdata_next   = out_rdata_reg;
        out_status_next  = out_status_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = sweep_addr_reg;
        ram_wr_data      = nfam_pkg::ERASED_BYTE;
        fin_valid        = 1'b0;
        fin_rdata        = '0;
        fin_status       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = operation;
                    addr_next  = item_sum[ADDR_W-1:0];
                    wdata_next = write_data;
                    unique case (operation) inside
                        nfam_pkg::OP_READ, nfam_pkg::OP_PROGRAM:
                        begin
                            if (run_ok)
                            begin
                                state_next = ST_MODIFY;
                            end
                            else
                            begin
                                fin_valid  = 1'b1;
                                fin_status = 1'b1;
                            end
                        end
                        nfam_pkg::OP_FAULT:
                        begin
                            if (addr_ok)
                            begin
                                state_next = ST_MODIFY;
                            end
                            else
                            begin
                                fin_valid  = 1'b1;
                                fin_status = 1'b1;
                            end
                        end
                        nfam_pkg::OP_SECTOR:
                        begin
                            if (addr_ok)
                            begin
                                state_next      = ST_SWEEP;
                                sweep_addr_next = sec_base[ADDR_W-1:0];
                                sweep_last_next = sec_last[ADDR_W-1:0];
                                report_next     = 1'b1;
                            end
                            else
                            begin
                                fin_valid  = 1'b1;
                                fin_status = 1'b1;
                            end
                        end
                        nfam_pkg::OP_CHIP:
                        begin
                            state_next      = ST_SWEEP;
                            sweep_addr_next = '0;
                            sweep_last_next = LAST_ADDR;
                            report_next     = 1'b1;
                        end
                        default:
                        begin
                            fin_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_MODIFY:
            begin
                // The stored byte arrived from the read issued at acceptance.
                fin_valid   = 1'b1;
                ram_wr_addr = addr_reg;
                unique case (op_reg)
                    nfam_pkg::OP_PROGRAM:
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data & wdata_reg;
                    end
                    nfam_pkg::OP_FAULT:
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data ^ nfam_pkg::FAULT_BIT;
                    end
                    default:
                    begin
                        fin_rdata = ram_rd_data;
                    end
                endcase
            end
            ST_SWEEP:
            begin
                ram_wr_en = 1'b1;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    // The clearing pass after reset has no beat to answer.
                    if (report_reg)
                    begin
                        fin_valid = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                end
            end
            ST_DONE:
            begin
                fin_valid  = 1'b1;
                fin_rdata  = pend_rdata_reg;
                fin_status = pend_status_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A finished result goes straight to the output register if it is free, otherwise
        // it is parked until the register frees.
        if (fin_valid)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_rdata_next  = fin_rdata;
                out_status_next = fin_status;
                state_next      = ST_IDLE;
            end
            else
            begin
                pend_rdata_next  = fin_rdata;
                pend_status_next = fin_status;
                state_next       = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // Reset starts the clearing pass over the whole array.
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            sweep_last_reg <= LAST_ADDR;
            report_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            report_reg     <= report_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        addr_reg        <= addr_next;
        wdata_reg       <= wdata_next;
        pend_rdata_reg  <= pend_rdata_next;
        pend_status_reg <= pend_status_next;
        out_rdata_reg   <= out_rdata_next;
        out_status_reg  <= out_status_next;
    end

    nfam_ram #(
        .WIDTH (nfam_pkg::DATA_W),
        .DEPTH (MEMORY_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign read_data = out_rdata_reg;
    assign status    = out_status_reg;

endmodule

[design/nfam_checker.sv]
// Port-level checker of the flash array model block, bound to its top level.
// Depends on nfam_pkg and nor_flash_array_model_unit_assert.svh.
`include "nor_flash_array_model_unit_assert.svh"

module nfam_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input nfam_pkg::op_t     operation,
    input nfam_pkg::start_t  start_address,
    input nfam_pkg::run_t    run_bytes,
    input nfam_pkg::offset_t byte_offset,
    input nfam_pkg::data_t   write_data,
    input logic              out_valid,
    input logic              out_stall,
    input nfam_pkg::data_t   read_data,
    input logic              status
);

    // Beats taken in but not yet delivered.
    logic [1:0] open_reg, open_next;
    logic       in_beat;
    logic       out_beat;
    logic       out_held;
    logic [nfam_pkg::DATA_W:0] out_word;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;
    assign out_held = out_valid && out_stall;
    assign out_word = {status, read_data};

    always_comb
    begin
        open_next = open_reg + 2'(in_beat) - 2'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    // From the first edge in reset the block takes nothing and shows nothing.
    `NFAM_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (in_stall && !out_valid), "active in reset")
    // A stalled result holds.
    `NFAM_ASSERT(a_out_hold, out_held |=> (out_valid && $stable(out_word)), "held result moved")
    // At most one beat in work plus one in the output register.
    `NFAM_ASSERT(a_open_bound, open_reg <= 2'd2, "too many beats outstanding")
    // No result without a beat that caused it.
    `NFAM_ASSERT(a_no_invented, out_valid |-> (open_reg != 2'd0), "result without a beat")

endmodule

bind nor_flash_array_model_unit nfam_checker u_nfam_checker (.*);
